@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the voxel ray march RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle whenever the antecedent holds.
`define VRM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Expression must never be true.
`define VRM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hw/rtl/vrm_pkg.sv @@
// Shared types and constants of the voxel ray marcher.
package vrm_pkg;

   localparam logic [7:0]  EMPTY_CODE   = 8'd32;
   localparam logic [7:0]  EDGE_CODE    = 8'd45;
   localparam logic [17:0] EPS_Q16      = 18'd655;
   localparam logic [17:0] DIST_CAP     = 18'd131072;
   localparam logic [15:0] BORDER_RESET = 16'd3277;
   localparam logic        ACT_WRITE    = 1'b0;
   localparam logic        ACT_TRACE    = 1'b1;

   // One classified item as it waits in the queue
   typedef struct packed {
      logic               is_trace;
      logic               wr_ok;
      logic [4:0]         vx;
      logic [4:0]         vy;
      logic [4:0]         vz;
      logic [7:0]         code;
      logic signed [23:0] ox;
      logic signed [23:0] oy;
      logic signed [23:0] oz;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [17:0] dz;
   } item_type;

endpackage

@@ hw/rtl/voxel_ray_march_top.sv @@
// A write passes through the queue into the store; a trace is marched through the grid step by step.
// Each march step runs through the bit-serial boundary dividers.
// Throughput: one item at a time in the back part; the queue between the parts holds up to two more.
// Reset: synchronous; afterwards a clearing pass over all 2^(sum of clog2 of the grid sizes) entries
// (32768 at 32x32x32) fills the store with the empty code and no beat is accepted.
// Configuration writes are taken at any time; border width resets to 3277.
`include "assert_macros.svh"

module voxel_ray_march_top import vrm_pkg::*; #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int MAX_STEPS = 256
) (
   input  logic         clock,
   input  logic         reset,
   // bits: voxel_x[4:0] voxel_y[9:5] voxel_z[14:10] voxel_code[22:15] origin_x[46:23]
   //       origin_y[70:47] origin_z[94:71] dir_x[112:95] dir_y[130:113] dir_z[148:131]
   input  logic [151:0] req_tdata,
   input  logic         req_tuser,   // action
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic [7:0]   rsp_tdata,   // pixel_code[7:0]
   output logic         rsp_tuser,   // missed
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   logic     clearing;
   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type q_item_in;
   item_type q_item_out;

   vrm_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item_in)
   );

   vrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (q_item_out)
   );

   vrm_back #(
      .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .MAX_STEPS(MAX_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item_out),
      .q_pop      (q_pop),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `VRM_ASSERT_IMP(a_no_accept_clear, clock, reset, clearing, !req_tready, "beat taken while clearing")
   `VRM_ASSERT_IMP(a_miss_is_empty, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == EMPTY_CODE, "miss without empty code")
   `VRM_ASSERT_NEVER(a_hit_not_empty, clock, reset, rsp_tvalid && !rsp_tuser && rsp_tdata == EMPTY_CODE, "hit reports empty code")
   `VRM_ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid, "pop from empty queue")

endmodule

@@ hw/rtl/vrm_ram.sv @@
// Generic single write port RAM with registered read.
module vrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/vrm_queue.sv @@
// Two-entry item queue between the front and back parts.
module vrm_queue import vrm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign valid     = (count_ff != 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/vrm_front.sv @@
// Front part: takes request beats, unpacks and classifies them.
module vrm_front import vrm_pkg::*; #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 32
) (
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic         req_tuser,
   input  logic         clearing,
   input  logic         q_full,
   output logic         q_push,
   output item_type     q_item
);

   localparam logic [6:0] GX = 7'(GRID_X);
   localparam logic [6:0] GY = 7'(GRID_Y);
   localparam logic [6:0] GZ = 7'(GRID_Z);

   // hold off while the store is being cleared or the queue is full
   assign req_tready = !q_full && !clearing;
   assign q_push     = req_tvalid && req_tready;

   // unpack the beat and flag writes that fall inside the grid
   always_comb begin
      q_item.is_trace = (req_tuser == ACT_TRACE);
      q_item.vx       = req_tdata[4:0];
      q_item.vy       = req_tdata[9:5];
      q_item.vz       = req_tdata[14:10];
      q_item.code     = req_tdata[22:15];
      q_item.ox       = req_tdata[46:23];
      q_item.oy       = req_tdata[70:47];
      q_item.oz       = req_tdata[94:71];
      q_item.dx       = req_tdata[112:95];
      q_item.dy       = req_tdata[130:113];
      q_item.dz       = req_tdata[148:131];
      q_item.wr_ok    = ({2'b00, q_item.vx} < GX) && ({2'b00, q_item.vy} < GY) &&
                        ({2'b00, q_item.vz} < GZ);
   end

endmodule

@@ hw/rtl/vrm_back.sv @@
// Back part: voxel store, clearing pass, ray march sequencer and result register.
module vrm_back import vrm_pkg::*; #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int MAX_STEPS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output logic        clearing,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tuser
);

   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);
   localparam int AW    = XW + YW + ZW;
   localparam int DEPTH = 1 << AW;
   localparam logic [7:0] GX  = 8'(GRID_X);
   localparam logic [7:0] GY  = 8'(GRID_Y);
   localparam logic [7:0] GZ  = 8'(GRID_Z);
   localparam logic [8:0] MAXS = 9'(MAX_STEPS);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_LOOK  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_MIN   = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_ADV   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [15:0]        border_ff, border_in;
   logic signed [23:0] pos_ff [3];
   logic signed [23:0] pos_in [3];
   logic signed [17:0] dir_ff [3];
   logic signed [17:0] dir_in [3];
   logic [8:0]         cnt_ff, cnt_in;
   logic [18:0]        rem_ff [3];
   logic [18:0]        rem_in [3];
   logic [16:0]        low_ff [3];
   logic [16:0]        low_in [3];
   logic [16:0]        quo_ff [3];
   logic [16:0]        quo_in [3];
   logic [17:0]        den_ff [3];
   logic [17:0]        den_in [3];
   logic [2:0]         sat_ff, sat_in;
   logic [2:0]         en_ff, en_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic [17:0]        dist_ff, dist_in;
   logic signed [36:0] prod_ff [3];
   logic signed [36:0] prod_in [3];
   logic [7:0]         res_code_ff, res_code_in;
   logic               res_miss_ff, res_miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_code_ff, rsp_code_in;
   logic               rsp_miss_ff, rsp_miss_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [7:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;
   logic               in_grid;
   logic [2:0]         near;
   logic [16:0]        frac_c [3];
   logic [16:0]        frac_d [3];
   logic [16:0]        m_num [3];
   logic [17:0]        d_mag [3];
   logic [18:0]        trial [3];
   logic [17:0]        q_axis [3];
   logic [17:0]        q_min;
   logic [36:0]        p_mag [3];
   logic [23:0]        p_step [3];

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_miss_ff;

   vrm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   // grid bounds and store address of the current position
   always_comb begin
      in_grid = !pos_ff[0][23] && (pos_ff[0][23:16] < GX) &&
                !pos_ff[1][23] && (pos_ff[1][23:16] < GY) &&
                !pos_ff[2][23] && (pos_ff[2][23:16] < GZ);
      ram_raddr = {pos_ff[2][16 +: ZW], pos_ff[1][16 +: YW], pos_ff[0][16 +: XW]};
   end

   // per-axis helpers: border distance, divider operands, step rounding
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         frac_c[a] = 17'h10000 - {1'b0, pos_ff[a][15:0]};
         frac_d[a] = ({1'b0, pos_ff[a][15:0]} < frac_c[a]) ? {1'b0, pos_ff[a][15:0]}
                                                         : frac_c[a];
         near[a]   = frac_d[a] < {1'b0, border_ff};
         m_num[a]  = (dir_ff[a] > 18'sd0) ? frac_c[a] : {1'b0, pos_ff[a][15:0]};
         d_mag[a]  = dir_ff[a][17] ? 18'(-dir_ff[a]) : 18'(dir_ff[a]);
         trial[a]  = {rem_ff[a][17:0], low_ff[a][16]};
         q_axis[a] = (!en_ff[a] || sat_ff[a]) ? DIST_CAP : {1'b0, quo_ff[a]};
         p_mag[a]  = prod_ff[a][36] ? 37'(-prod_ff[a]) : 37'(prod_ff[a]);
         p_step[a] = 24'((p_mag[a] + 37'd32768) >> 16);
      end
      q_min = DIST_CAP;
      for (int a = 0; a < 3; a++) begin
         if (q_axis[a] < q_min) begin
            q_min = q_axis[a];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      border_in    = csr_we ? csr_wdata : border_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;
      en_in        = en_ff;
      div_cnt_in   = div_cnt_ff;
      dist_in      = dist_ff;
      res_code_in  = res_code_ff;
      res_miss_in  = res_miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_miss_in  = rsp_miss_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = {ZW'(q_item.vz), YW'(q_item.vy), XW'(q_item.vx)};
      ram_wdata    = q_item.code;
      for (int a = 0; a < 3; a++) begin
         pos_in[a]  = pos_ff[a];
         dir_in[a]  = dir_ff[a];
         rem_in[a]  = rem_ff[a];
         low_in[a]  = low_ff[a];
         quo_in[a]  = quo_ff[a];
         den_in[a]  = den_ff[a];
         prod_in[a] = prod_ff[a];
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep the store with the empty code
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = EMPTY_CODE;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_trace) begin
                  pos_in[0] = q_item.ox;
                  pos_in[1] = q_item.oy;
                  pos_in[2] = q_item.oz;
                  dir_in[0] = q_item.dx;
                  dir_in[1] = q_item.dy;
                  dir_in[2] = q_item.dz;
                  cnt_in    = 9'd0;
                  state_in  = ST_CHECK;
               end else begin
                  ram_we = q_item.wr_ok;
               end
            end
         end
         ST_CHECK: begin
            // leaving the grid ends the march, else the read is under way
            if (!in_grid) begin
               res_code_in = EMPTY_CODE;
               res_miss_in = 1'b1;
               state_in    = ST_OUT;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (ram_rdata != EMPTY_CODE) begin
               res_code_in = ((near[0] && near[1]) || (near[0] && near[2]) ||
                              (near[1] && near[2])) ? EDGE_CODE : ram_rdata;
               res_miss_in = 1'b0;
               state_in    = ST_OUT;
            end else if (cnt_ff >= MAXS) begin
               res_code_in = EMPTY_CODE;
               res_miss_in = 1'b1;
               state_in    = ST_OUT;
            end else begin
               // load the three dividers
               for (int a = 0; a < 3; a++) begin
                  en_in[a]  = (dir_ff[a] > $signed({1'b0, EPS_Q16})) ||
                              (dir_ff[a] < -$signed({1'b0, EPS_Q16}));
                  sat_in[a] = {2'b00, m_num[a]} >= {d_mag[a], 1'b0};
                  rem_in[a] = 19'(m_num[a][16:1]);
                  low_in[a] = {m_num[a][0], 16'd0};
                  quo_in[a] = 17'd0;
                  den_in[a] = d_mag[a];
               end
               div_cnt_in = 5'd16;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per axis each cycle
            for (int a = 0; a < 3; a++) begin
               if (trial[a] >= {1'b0, den_ff[a]}) begin
                  rem_in[a] = trial[a] - {1'b0, den_ff[a]};
                  quo_in[a] = {quo_ff[a][15:0], 1'b1};
               end else begin
                  rem_in[a] = trial[a];
                  quo_in[a] = {quo_ff[a][15:0], 1'b0};
               end
               low_in[a] = {low_ff[a][15:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd0) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            dist_in  = q_min + EPS_Q16;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            for (int a = 0; a < 3; a++) begin
               prod_in[a] = $signed({1'b0, dist_ff}) * dir_ff[a];
            end
            state_in = ST_ADV;
         end
         ST_ADV: begin
            // move by the rounded step and count it
            for (int a = 0; a < 3; a++) begin
               pos_in[a] = prod_ff[a][36] ? pos_ff[a] - $signed(p_step[a])
                                          : pos_ff[a] + $signed(p_step[a]);
            end
            cnt_in   = cnt_ff + 9'd1;
            state_in = ST_CHECK;
         end
         ST_OUT: begin
            // hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_miss_in  = res_miss_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         border_ff    <= BORDER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         border_ff    <= border_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sat_ff      <= sat_in;
      en_ff       <= en_in;
      div_cnt_ff  <= div_cnt_in;
      dist_ff     <= dist_in;
      res_code_ff <= res_code_in;
      res_miss_ff <= res_miss_in;
      rsp_code_ff <= rsp_code_in;
      rsp_miss_ff <= rsp_miss_in;
      for (int a = 0; a < 3; a++) begin
         pos_ff[a]  <= pos_in[a];
         dir_ff[a]  <= dir_in[a];
         rem_ff[a]  <= rem_in[a];
         low_ff[a]  <= low_in[a];
         quo_ff[a]  <= quo_in[a];
         den_ff[a]  <= den_in[a];
         prod_ff[a] <= prod_in[a];
      end
   end

endmodule
